// ----- rtl/ksv_pkg.sv -----
// package with shared types, register codes and the sine table function for the string voice
package ksv_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int GAIN_W     = 17;
	localparam int COEF_W     = 16;
	localparam int WAVE_SEL_W = 3;
	localparam int LEN_W      = 12;
	localparam int LAG_W      = 10;
	localparam int PHASE_W    = 16;
	localparam int LFSR_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_DECAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_WAVEFORM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_GAIN_STEP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 3'd6;

	localparam logic [WAVE_SEL_W-1:0] WAVE_NOISE    = 3'd0;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 3'd1;
	localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 3'd2;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE   = 3'd3;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SAW      = 3'd4;

	localparam logic [LAG_W-1:0]      RST_DELAY_SAMPLES   = 10'd240;
	localparam logic [COEF_W-1:0]     RST_FEEDBACK_DECAY  = 16'd64880;
	localparam logic [COEF_W-1:0]     RST_LOWPASS_COEFF   = 16'd26000;
	localparam logic [WAVE_SEL_W-1:0] RST_BURST_WAVEFORM  = WAVE_NOISE;
	localparam logic [LEN_W-1:0]      RST_BURST_LENGTH    = 12'd480;
	localparam logic [COEF_W-1:0]     RST_BURST_GAIN_STEP = 16'd137;
	localparam logic [PHASE_W-1:0]    RST_PHASE_STEP      = 16'd1092;

	localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
	localparam logic [LFSR_W-1:0] LFSR_SEED  = 32'hACE1ACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'hA3000000;

	typedef struct packed {
		logic [LAG_W-1:0]      delay_samples;
		logic [COEF_W-1:0]     feedback_decay;
		logic [COEF_W-1:0]     lowpass_coeff;
		logic [WAVE_SEL_W-1:0] burst_waveform;
		logic [LEN_W-1:0]      burst_length;
		logic [COEF_W-1:0]     burst_gain_step;
		logic [PHASE_W-1:0]    phase_step;
	} ksv_cfg_t;

	typedef struct packed {
		logic pluck_load;
		logic step;
	} ksv_exc_ctrl_t;

	// quarter-wave polynomial, Q1.15 result
	function automatic longint unsigned quarter_sine(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		begin
			x2 = (x * x) >> 16;
			t = (64'd1190 * x2) >> 16;
			t = 64'd10541 - t;
			t = (t * x2) >> 16;
			t = 64'd25736 - t;
			t = ((t * x) >> 16) << 1;
			quarter_sine = (t > 64'd32767) ? 64'd32767 : t;
		end
	endfunction

	// table entry for a 16-bit phase
	function automatic logic signed [15:0] sine_value(input longint unsigned ph);
		longint unsigned q;
		longint unsigned x;
		longint unsigned s;
		logic signed [15:0] sv;
		begin
			q = (ph >> 14) & 64'd3;
			x = (ph & 64'h3FFF) << 2;
			s = quarter_sine(q[0] ? (64'd65536 - x) : x);
			sv = s[15:0];
			sine_value = q[1] ? -sv : sv;
		end
	endfunction

endpackage

// ----- rtl/ksv_pluck_if.sv -----
// input channel carrying one sample tick with its pluck flag
interface ksv_pluck_if;
	logic valid;
	logic ready;
	logic pluck;

	modport source (output valid, output pluck, input ready);
	modport sink (input valid, input pluck, output ready);
endinterface

// ----- rtl/ksv_sample_if.sv -----
// output channel carrying one delayed string sample
interface ksv_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ----- rtl/ksv_smul.sv -----
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle, result scaled by 2^-16
module ksv_smul #(
	parameter int MW = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [MW-1:0]              mcand,
	input  logic        [ksv_pkg::GAIN_W-1:0] mplier,
	output logic                              busy,
	output logic signed [MW+1:0]              prod
);
	import ksv_pkg::*;

	localparam int CW = $clog2(GAIN_W + 1);

	logic [CW-1:0]       cnt_q;
	logic signed [MW:0]  hi_q;
	logic [GAIN_W-1:0]   lo_q;
	logic [GAIN_W-1:0]   u_q;
	logic signed [MW-1:0] m_q;
	logic signed [MW:0]  sum;

	assign sum  = hi_q + (u_q[0] ? {m_q[MW-1], m_q} : '0);
	assign busy = (cnt_q != '0);
	assign prod = {hi_q, lo_q[GAIN_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(GAIN_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q  <= mcand;
			u_q  <= mplier;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[GAIN_W-1:1]};
			u_q  <= u_q >> 1;
		end
	end
endmodule

// ----- rtl/ksv_exciter.sv -----
// excitation burst: countdown, falling gain, oscillator phase, noise and waveform shaping
module ksv_exciter #(
	parameter int SAMPLE_WIDTH     = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ksv_pkg::ksv_cfg_t                 cfg,
	input  ksv_pkg::ksv_exc_ctrl_t            ctrl,
	output logic                              active,
	output logic        [ksv_pkg::GAIN_W-1:0] gain,
	output logic signed [SAMPLE_WIDTH-1:0]    wave
);
	import ksv_pkg::*;

	localparam int SIW = $clog2(SINE_TABLE_DEPTH);

	logic [LEN_W-1:0]   rem_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [PHASE_W-1:0] phase_q;
	logic [LFSR_W-1:0]  lfsr_q;

	logic [LFSR_W-1:0]  lfsr_next;
	logic [LEN_W-1:0]   rem_next;
	logic [31:0]        idx_full;
	logic [SIW-1:0]     sine_idx;
	logic signed [17:0] tri_w;
	logic signed [17:0] two_p;
	logic signed [15:0] v16;
	logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
		localparam longint unsigned PH =
			((longint'(i) * 65536) / SINE_TABLE_DEPTH) & 64'hFFFF;
		assign sine_rom[i] = sine_value(PH);
	end

	assign active    = (rem_q != '0) && (gain_q != '0);
	assign gain      = gain_q;
	assign lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
	assign rem_next  = rem_q - 1'b1;
	assign idx_full  = 32'(phase_q) * 32'(SINE_TABLE_DEPTH);
	assign sine_idx  = idx_full[16 +: SIW];
	assign two_p     = $signed({1'b0, phase_q, 1'b0});

	always_comb begin
		if (!phase_q[15]) begin
			tri_w = two_p - 18'sd32768;
		end else begin
			tri_w = 18'sd98304 - two_p;
		end
		if (tri_w > 18'sd32767) begin
			tri_w = 18'sd32767;
		end
	end

	always_comb begin
		case (cfg.burst_waveform)
			WAVE_NOISE:    v16 = lfsr_next[LFSR_W-1 -: 16];
			WAVE_SINE:     v16 = sine_rom[sine_idx];
			WAVE_TRIANGLE: v16 = tri_w[15:0];
			WAVE_SQUARE:   v16 = phase_q[15] ? 16'sh8000 : 16'sh7FFF;
			WAVE_SAW:      v16 = phase_q ^ 16'h8000;
			default:       v16 = '0;
		endcase
	end

	if (SAMPLE_WIDTH >= 16) begin : g_up
		assign wave = SAMPLE_WIDTH'(v16) <<< (SAMPLE_WIDTH - 16);
	end else begin : g_down
		logic signed [15:0] v_sh;
		assign v_sh = v16 >>> (16 - SAMPLE_WIDTH);
		assign wave = v_sh[SAMPLE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			gain_q  <= '0;
			phase_q <= '0;
			lfsr_q  <= LFSR_SEED;
		end else if (ctrl.pluck_load) begin
			rem_q   <= (cfg.burst_length != '0) ? cfg.burst_length : LEN_W'(1);
			gain_q  <= GAIN_ONE;
			phase_q <= '0;
		end else if (ctrl.step && active) begin
			rem_q <= rem_next;
			if (rem_next == '0) begin
				gain_q <= '0;
			end else if (gain_q > GAIN_W'(cfg.burst_gain_step)) begin
				gain_q <= gain_q - GAIN_W'(cfg.burst_gain_step);
			end else begin
				gain_q <= '0;
			end
			if (cfg.burst_waveform == WAVE_NOISE) begin
				lfsr_q <= lfsr_next;
			end else begin
				phase_q <= phase_q + cfg.phase_step;
			end
		end
	end
endmodule

// ----- rtl/ksv_dline.sv -----
// string delay line memory with write pointer, lag read and fill tracking
module ksv_dline #(
	parameter int DELAY_DEPTH  = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ksv_pkg::LAG_W-1:0]        lag,
	input  logic                             rd_en,
	output logic signed [SAMPLE_WIDTH-1:0]   rd_data,
	input  logic                             wr_en,
	input  logic signed [SAMPLE_WIDTH-1:0]   wr_data
);
	import ksv_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);

	logic signed [SAMPLE_WIDTH-1:0] mem [DELAY_DEPTH];
	logic [AW-1:0]                  wp_q;
	logic                           wrapped_q;
	logic signed [SAMPLE_WIDTH-1:0] rdata_q;
	logic                           rvalid_q;

	logic [31:0]   lag_w;
	logic [AW-1:0] lag_c;
	logic [AW-1:0] rd_addr;

	always_comb begin
		lag_w = 32'(lag);
		if (lag_w < 32'd1) begin
			lag_w = 32'd1;
		end
		if (lag_w > 32'(DELAY_DEPTH - 2)) begin
			lag_w = 32'(DELAY_DEPTH - 2);
		end
		lag_c = lag_w[AW-1:0];
		if (wp_q >= lag_c) begin
			rd_addr = wp_q - lag_c;
		end else begin
			rd_addr = wp_q + AW'(DELAY_DEPTH) - lag_c;
		end
	end

	// never-written entries read as zero
	assign rd_data = rvalid_q ? rdata_q : '0;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rvalid_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rvalid_q <= wrapped_q || (rd_addr < wp_q);
			end
			if (wr_en) begin
				if (wp_q == AW'(DELAY_DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/plucked_string_synth_voice_core.sv -----
// top level of the plucked string voice: config registers, sequencer, filter and feedback path
//
//  channel    | dir | payload              | transfer when
//  pluck_ch   | in  | pluck                | valid && ready
//  sample_ch  | out | sample_out           | valid && ready
//  cfg port   | in  | cfg_index, cfg_data  | cfg_we
//
//  per sample: accept and delay read, then the lowpass and feedback
//  products, each a bit-serial multiply, run one after the other
//  the burst product runs on a second serial multiplier alongside the lowpass one
//  the delayed sample goes to the output register and may wait there; the next tick
//  is taken meanwhile and stalls in its load step until that register frees
//  no clearing pass after reset: a fill marker makes unwritten delay entries read zero
module plucked_string_synth_voice_core #(
	parameter int DELAY_DEPTH      = 1024,
	parameter int SAMPLE_WIDTH     = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ksv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ksv_pkg::CFG_DATA_W-1:0]     cfg_data,
	ksv_pluck_if.sink                          pluck_ch,
	ksv_sample_if.source                       sample_ch
);
	import ksv_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int MW = SW + 1;
	localparam int PW = MW + 2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_LP   = 3'd2;
	localparam logic [2:0] S_FB   = 3'd3;

	localparam logic signed [SW+1:0] Y_MAX = (SW+2)'((64'sd1 <<< (SW - 1)) - 1);
	localparam logic signed [SW+1:0] Y_MIN = (SW+2)'(-(64'sd1 <<< (SW - 1)));

	ksv_cfg_t      cfg_q;
	ksv_exc_ctrl_t exc_ctrl;

	logic [2:0]           state_q;
	logic signed [SW-1:0] lp_q;
	logic signed [SW:0]   excite_q;
	logic signed [SW-1:0] out_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 out_free;
	logic                 load_go;
	logic                 lp_done;
	logic                 fb_done;
	logic                 exc_active;
	logic [GAIN_W-1:0]    exc_gain;
	logic signed [SW-1:0] exc_wave;
	logic signed [SW-1:0] delayed;
	logic signed [SW-1:0] lp_next;
	logic signed [SW+1:0] lp_sum;
	logic signed [SW+1:0] y_sum;
	logic signed [SW-1:0] y_sat;
	logic signed [MW-1:0] diff;
	logic signed [MW-1:0] mcand_a;
	logic [GAIN_W-1:0]    mplier_a;
	logic [GAIN_W-1:0]    mplier_b;
	logic                 start_a;
	logic                 busy_a;
	logic                 busy_b;
	logic signed [PW-1:0] prod_a;
	logic signed [PW-1:0] prod_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_samples   <= RST_DELAY_SAMPLES;
			cfg_q.feedback_decay  <= RST_FEEDBACK_DECAY;
			cfg_q.lowpass_coeff   <= RST_LOWPASS_COEFF;
			cfg_q.burst_waveform  <= RST_BURST_WAVEFORM;
			cfg_q.burst_length    <= RST_BURST_LENGTH;
			cfg_q.burst_gain_step <= RST_BURST_GAIN_STEP;
			cfg_q.phase_step      <= RST_PHASE_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY_SAMPLES:   cfg_q.delay_samples   <= cfg_data[LAG_W-1:0];
				REG_FEEDBACK_DECAY:  cfg_q.feedback_decay  <= cfg_data[COEF_W-1:0];
				REG_LOWPASS_COEFF:   cfg_q.lowpass_coeff   <= cfg_data[COEF_W-1:0];
				REG_BURST_WAVEFORM:  cfg_q.burst_waveform  <= cfg_data[WAVE_SEL_W-1:0];
				REG_BURST_LENGTH:    cfg_q.burst_length    <= cfg_data[LEN_W-1:0];
				REG_BURST_GAIN_STEP: cfg_q.burst_gain_step <= cfg_data[COEF_W-1:0];
				REG_PHASE_STEP:      cfg_q.phase_step      <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign pluck_ch.ready     = (state_q == S_IDLE);
	assign accept             = pluck_ch.valid && (state_q == S_IDLE);
	assign out_free           = !out_valid_q || sample_ch.ready;
	assign load_go            = (state_q == S_LOAD) && out_free;
	assign lp_done            = (state_q == S_LP) && !busy_a && !busy_b;
	assign fb_done            = (state_q == S_FB) && !busy_a;
	assign sample_ch.valid    = out_valid_q;
	assign sample_ch.sample_out = out_q;

	assign exc_ctrl.pluck_load = accept && pluck_ch.pluck;
	assign exc_ctrl.step       = load_go;

	// lowpass update and feedback sum
	assign diff    = {delayed[SW-1], delayed} - {lp_q[SW-1], lp_q};
	assign lp_sum  = {{2{lp_q[SW-1]}}, lp_q} + {prod_a[SW], prod_a[SW:0]};
	assign lp_next = lp_sum[SW-1:0];
	assign y_sum   = {excite_q[SW], excite_q} + {prod_a[SW], prod_a[SW:0]};

	always_comb begin
		if (y_sum > Y_MAX) begin
			y_sat = Y_MAX[SW-1:0];
		end else if (y_sum < Y_MIN) begin
			y_sat = Y_MIN[SW-1:0];
		end else begin
			y_sat = y_sum[SW-1:0];
		end
	end

	assign start_a  = load_go || lp_done;
	assign mcand_a  = load_go ? diff : {lp_next[SW-1], lp_next};
	assign mplier_a = load_go ? {1'b0, cfg_q.lowpass_coeff} : {1'b0, cfg_q.feedback_decay};
	assign mplier_b = exc_active ? exc_gain : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			lp_q        <= '0;
		end else begin
			if (load_go) begin
				out_valid_q <= 1'b1;
			end else if (sample_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (lp_done) begin
				lp_q <= lp_next;
			end
			case (state_q)
				S_IDLE: if (accept) state_q <= S_LOAD;
				S_LOAD: if (out_free) state_q <= S_LP;
				S_LP:   if (!busy_a && !busy_b) state_q <= S_FB;
				S_FB:   if (!busy_a) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_go) begin
			out_q <= delayed;
		end
		if (lp_done) begin
			excite_q <= prod_b[SW:0];
		end
	end

	ksv_dline #(
		.DELAY_DEPTH  (DELAY_DEPTH),
		.SAMPLE_WIDTH (SW)
	) u_dline (
		.clk     (clk),
		.arst_n  (arst_n),
		.lag     (cfg_q.delay_samples),
		.rd_en   (accept),
		.rd_data (delayed),
		.wr_en   (fb_done),
		.wr_data (y_sat)
	);

	ksv_exciter #(
		.SAMPLE_WIDTH     (SW),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_exciter (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctrl   (exc_ctrl),
		.active (exc_active),
		.gain   (exc_gain),
		.wave   (exc_wave)
	);

	ksv_smul #(
		.MW (MW)
	) u_mul_filt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_a),
		.mcand  (mcand_a),
		.mplier (mplier_a),
		.busy   (busy_a),
		.prod   (prod_a)
	);

	ksv_smul #(
		.MW (MW)
	) u_mul_burst (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load_go),
		.mcand  ({exc_wave[SW-1], exc_wave}),
		.mplier (mplier_b),
		.busy   (busy_b),
		.prod   (prod_b)
	);
endmodule
